[rtl/ssc_pkg.sv]
package ssc_pkg;

  // parameter fraction bits
  localparam int unsigned PARAM_FRAC_BITS = 16;

  // datapath widths
  localparam int unsigned CW     = 32;            // coordinate
  localparam int unsigned DW     = CW + 1;        // coordinate difference
  localparam int unsigned PW     = 2 * DW;        // difference product
  localparam int unsigned SW     = PW + 2;        // dot product
  localparam int unsigned MW     = 2 * SW;        // product of two dot products
  localparam int unsigned WW     = MW + 2;        // determinant and numerators
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned OUT_W  = PARAM_FRAC_BITS + 1;

  // multiplier limb split
  localparam int unsigned NLIMB = 3;
  localparam int unsigned LIMB  = (SW + NLIMB - 1) / NLIMB;
  localparam int unsigned MAGW  = LIMB * NLIMB;

  // latencies
  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned DIV_LAT   = PARAM_FRAC_BITS + 1;
  localparam int unsigned TOTAL_LAT = 3 + MUL_LAT + 3 + DIV_LAT + 1;

  localparam logic [OUT_W-1:0] PARAM_ONE = OUT_W'(1) << PARAM_FRAC_BITS;

endpackage

[rtl/ssc_mul.sv]
module ssc_mul (
  input  logic                          clk_i,
  input  logic signed [ssc_pkg::SW-1:0] x_i,
  input  logic signed [ssc_pkg::SW-1:0] y_i,
  output logic signed [ssc_pkg::MW-1:0] p_o
);

  localparam int unsigned NPP = ssc_pkg::NLIMB * ssc_pkg::NLIMB;

  logic [ssc_pkg::SW-1:0]     xa, ya;
  logic [ssc_pkg::MAGW-1:0]   xm_q, ym_q;
  logic                       neg1_q, neg2_q, neg3_q;
  logic [2*ssc_pkg::LIMB-1:0] pp_q [NPP];
  logic [2*ssc_pkg::MAGW-1:0] sum_d, sum_q;

  // magnitudes
  assign xa = x_i[ssc_pkg::SW-1] ? ssc_pkg::SW'(-x_i) : ssc_pkg::SW'(x_i);
  assign ya = y_i[ssc_pkg::SW-1] ? ssc_pkg::SW'(-y_i) : ssc_pkg::SW'(y_i);

  always_ff @(posedge clk_i) begin
    xm_q   <= ssc_pkg::MAGW'(xa);
    ym_q   <= ssc_pkg::MAGW'(ya);
    neg1_q <= x_i[ssc_pkg::SW-1] ^ y_i[ssc_pkg::SW-1];
  end

  // limb partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ssc_pkg::NLIMB; i++) begin
      for (int j = 0; j < ssc_pkg::NLIMB; j++) begin
        pp_q[i*ssc_pkg::NLIMB+j] <= xm_q[i*ssc_pkg::LIMB +: ssc_pkg::LIMB]
                                  * ym_q[j*ssc_pkg::LIMB +: ssc_pkg::LIMB];
      end
    end
    neg2_q <= neg1_q;
  end

  // weighted sum of partial products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < ssc_pkg::NLIMB; i++) begin
      for (int j = 0; j < ssc_pkg::NLIMB; j++) begin
        sum_d = sum_d + ((2*ssc_pkg::MAGW)'(pp_q[i*ssc_pkg::NLIMB+j])
                         << (ssc_pkg::LIMB * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    neg3_q <= neg2_q;
  end

  // restore sign
  always_ff @(posedge clk_i) begin
    p_o <= neg3_q ? -$signed(sum_q[ssc_pkg::MW-1:0]) : $signed(sum_q[ssc_pkg::MW-1:0]);
  end

endmodule

[rtl/ssc_div.sv]
module ssc_div (
  input  logic                             clk_i,
  input  logic signed [ssc_pkg::WW-1:0]    num_i,
  input  logic signed [ssc_pkg::WW-1:0]    den_i,
  output logic        [ssc_pkg::OUT_W-1:0] q_o
);

  localparam int unsigned F = ssc_pkg::PARAM_FRAC_BITS;

  logic [ssc_pkg::WW-1:0] rem_q  [F+1];
  logic [ssc_pkg::WW-1:0] d_q    [F+1];
  logic [F-1:0]           q_q    [F+1];
  logic                   zero_q [F+1];
  logic                   one_q  [F+1];
  logic                   nonpos;

  // clamp detection
  assign nonpos = num_i[ssc_pkg::WW-1] || (num_i == '0);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    d_q[0]    <= den_i;
    q_q[0]    <= '0;
    zero_q[0] <= nonpos;
    one_q[0]  <= !nonpos && (num_i >= den_i);
  end

  // one quotient bit per stage
  for (genvar i = 0; i < F; i++) begin : g_stage
    logic [ssc_pkg::WW:0] rem2, dd, nxt;
    logic                 ge;

    assign rem2 = {rem_q[i], 1'b0};
    assign dd   = {1'b0, d_q[i]};
    assign ge   = rem2 >= dd;
    assign nxt  = ge ? (rem2 - dd) : rem2;

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= nxt[ssc_pkg::WW-1:0];
      d_q[i+1]    <= d_q[i];
      q_q[i+1]    <= {q_q[i][F-2:0], ge};
      zero_q[i+1] <= zero_q[i];
      one_q[i+1]  <= one_q[i];
    end
  end

  always_comb begin
    priority if (zero_q[F]) begin
      q_o = '0;
    end else if (one_q[F]) begin
      q_o = ssc_pkg::PARAM_ONE;
    end else begin
      q_o = {1'b0, q_q[F]};
    end
  end

endmodule

[rtl/segment_segment_closest_params.sv]
// throughput: one item per cycle, busy_o is never raised
// the 17 stage quotient pipelines and the 4 stage wide multipliers make up most of the latency
// reset clears all valid bits and sets parallel_limit to one; no clearing pass
// results cannot be stalled by the receiver, every item comes out after the same latency
module segment_segment_closest_params (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  parallel_limit_we_i,
  input  logic        [ssc_pkg::LIMIT_W-1:0]    parallel_limit_i,
  input  logic signed [ssc_pkg::CW-1:0]         a_x_i,
  input  logic signed [ssc_pkg::CW-1:0]         a_y_i,
  input  logic signed [ssc_pkg::CW-1:0]         a_z_i,
  input  logic signed [ssc_pkg::CW-1:0]         b_x_i,
  input  logic signed [ssc_pkg::CW-1:0]         b_y_i,
  input  logic signed [ssc_pkg::CW-1:0]         b_z_i,
  input  logic signed [ssc_pkg::CW-1:0]         p_x_i,
  input  logic signed [ssc_pkg::CW-1:0]         p_y_i,
  input  logic signed [ssc_pkg::CW-1:0]         p_z_i,
  input  logic signed [ssc_pkg::CW-1:0]         q_x_i,
  input  logic signed [ssc_pkg::CW-1:0]         q_y_i,
  input  logic signed [ssc_pkg::CW-1:0]         q_z_i,
  output logic                                  done_o,
  output logic        [ssc_pkg::OUT_W-1:0]      param_first_o,
  output logic        [ssc_pkg::OUT_W-1:0]      param_second_o,
  output logic                                  parallel_error_o
);

  localparam int unsigned ML = ssc_pkg::MUL_LAT;
  localparam int unsigned DL = ssc_pkg::DIV_LAT;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  // configuration register
  logic [ssc_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ssc_pkg::LIMIT_W'(1);
    end else if (parallel_limit_we_i) begin
      limit_q <= parallel_limit_i;
    end
  end

  // valid chain
  logic          v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, done_q;
  logic [ML-1:0] vm_q;
  logic [DL-1:0] vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vm_q   <= '0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      vd_q   <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vm_q   <= {vm_q[ML-2:0], v3_q};
      v4_q   <= vm_q[ML-1];
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      vd_q   <= {vd_q[DL-2:0], v6_q};
      done_q <= vd_q[DL-1];
    end
  end

  // stage 1: edge vectors da = b - a, db = q - p, r = a - p
  logic signed [ssc_pkg::DW-1:0] da_q [3];
  logic signed [ssc_pkg::DW-1:0] db_q [3];
  logic signed [ssc_pkg::DW-1:0] r_q  [3];

  always_ff @(posedge clk_i) begin
    da_q[0] <= ssc_pkg::DW'(b_x_i) - ssc_pkg::DW'(a_x_i);
    da_q[1] <= ssc_pkg::DW'(b_y_i) - ssc_pkg::DW'(a_y_i);
    da_q[2] <= ssc_pkg::DW'(b_z_i) - ssc_pkg::DW'(a_z_i);
    db_q[0] <= ssc_pkg::DW'(q_x_i) - ssc_pkg::DW'(p_x_i);
    db_q[1] <= ssc_pkg::DW'(q_y_i) - ssc_pkg::DW'(p_y_i);
    db_q[2] <= ssc_pkg::DW'(q_z_i) - ssc_pkg::DW'(p_z_i);
    r_q[0]  <= ssc_pkg::DW'(a_x_i) - ssc_pkg::DW'(p_x_i);
    r_q[1]  <= ssc_pkg::DW'(a_y_i) - ssc_pkg::DW'(p_y_i);
    r_q[2]  <= ssc_pkg::DW'(a_z_i) - ssc_pkg::DW'(p_z_i);
  end

  // stage 2: per-axis products that form the dot products
  logic signed [ssc_pkg::PW-1:0] pa_q [3];
  logic signed [ssc_pkg::PW-1:0] pe_q [3];
  logic signed [ssc_pkg::PW-1:0] pb_q [3];
  logic signed [ssc_pkg::PW-1:0] pc_q [3];
  logic signed [ssc_pkg::PW-1:0] pf_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= ssc_pkg::PW'(da_q[k]) * ssc_pkg::PW'(da_q[k]);
      pe_q[k] <= ssc_pkg::PW'(db_q[k]) * ssc_pkg::PW'(db_q[k]);
      pb_q[k] <= ssc_pkg::PW'(da_q[k]) * ssc_pkg::PW'(db_q[k]);
      pc_q[k] <= ssc_pkg::PW'(da_q[k]) * ssc_pkg::PW'(r_q[k]);
      pf_q[k] <= ssc_pkg::PW'(db_q[k]) * ssc_pkg::PW'(r_q[k]);
    end
  end

  // stage 3: dot products a, e, b, c, f
  logic signed [ssc_pkg::SW-1:0] a_q, e_q, b_q, c_q, f_q;

  always_ff @(posedge clk_i) begin
    a_q <= ssc_pkg::SW'(pa_q[0]) + ssc_pkg::SW'(pa_q[1]) + ssc_pkg::SW'(pa_q[2]);
    e_q <= ssc_pkg::SW'(pe_q[0]) + ssc_pkg::SW'(pe_q[1]) + ssc_pkg::SW'(pe_q[2]);
    b_q <= ssc_pkg::SW'(pb_q[0]) + ssc_pkg::SW'(pb_q[1]) + ssc_pkg::SW'(pb_q[2]);
    c_q <= ssc_pkg::SW'(pc_q[0]) + ssc_pkg::SW'(pc_q[1]) + ssc_pkg::SW'(pc_q[2]);
    f_q <= ssc_pkg::SW'(pf_q[0]) + ssc_pkg::SW'(pf_q[1]) + ssc_pkg::SW'(pf_q[2]);
  end

  // wide products, split over limbs
  logic signed [ssc_pkg::MW-1:0] ae, bb, bf, ce, af, bc;

  ssc_mul u_mul_ae (.clk_i(clk_i), .x_i(a_q), .y_i(e_q), .p_o(ae));
  ssc_mul u_mul_bb (.clk_i(clk_i), .x_i(b_q), .y_i(b_q), .p_o(bb));
  ssc_mul u_mul_bf (.clk_i(clk_i), .x_i(b_q), .y_i(f_q), .p_o(bf));
  ssc_mul u_mul_ce (.clk_i(clk_i), .x_i(c_q), .y_i(e_q), .p_o(ce));
  ssc_mul u_mul_af (.clk_i(clk_i), .x_i(a_q), .y_i(f_q), .p_o(af));
  ssc_mul u_mul_bc (.clk_i(clk_i), .x_i(b_q), .y_i(c_q), .p_o(bc));

  // dot products ride along with the multipliers
  logic signed [ssc_pkg::SW-1:0] a_m_q [ML];
  logic signed [ssc_pkg::SW-1:0] e_m_q [ML];
  logic signed [ssc_pkg::SW-1:0] b_m_q [ML];
  logic signed [ssc_pkg::SW-1:0] c_m_q [ML];
  logic signed [ssc_pkg::SW-1:0] f_m_q [ML];

  always_ff @(posedge clk_i) begin
    a_m_q[0] <= a_q;
    e_m_q[0] <= e_q;
    b_m_q[0] <= b_q;
    c_m_q[0] <= c_q;
    f_m_q[0] <= f_q;
    for (int k = 1; k < ML; k++) begin
      a_m_q[k] <= a_m_q[k-1];
      e_m_q[k] <= e_m_q[k-1];
      b_m_q[k] <= b_m_q[k-1];
      c_m_q[k] <= c_m_q[k-1];
      f_m_q[k] <= f_m_q[k-1];
    end
  end

  // stage 4: determinant and the two unclamped numerators
  logic signed [ssc_pkg::WW-1:0] den4_q, sn4_q, tn4_q;
  logic signed [ssc_pkg::SW-1:0] a4_q, e4_q, b4_q, c4_q, f4_q;

  always_ff @(posedge clk_i) begin
    den4_q <= ssc_pkg::WW'(ae) - ssc_pkg::WW'(bb);
    sn4_q  <= ssc_pkg::WW'(bf) - ssc_pkg::WW'(ce);
    tn4_q  <= ssc_pkg::WW'(af) - ssc_pkg::WW'(bc);
    a4_q   <= a_m_q[ML-1];
    e4_q   <= e_m_q[ML-1];
    b4_q   <= b_m_q[ML-1];
    c4_q   <= c_m_q[ML-1];
    f4_q   <= f_m_q[ML-1];
  end

  // stage 5: parallel test, clamp of s and choice of the t ratio
  logic signed [ssc_pkg::WW-1:0] lim_w;
  logic                          sn_nonpos, sn_big;
  logic signed [ssc_pkg::WW-1:0] sn5_d, sd5_d, tn5_d, td5_d;
  logic signed [ssc_pkg::WW-1:0] sn5_q, sd5_q, tn5_q, td5_q;
  logic signed [ssc_pkg::SW-1:0] a5_q, b5_q, c5_q;
  logic                          par5_q;

  assign lim_w     = ssc_pkg::WW'(limit_q);
  assign sn_nonpos = sn4_q[ssc_pkg::WW-1] || (sn4_q == '0);
  assign sn_big    = sn4_q >= den4_q;

  always_comb begin
    priority if (sn_nonpos) begin
      // s clamps to zero, t = f / e
      sn5_d = '0;
      sd5_d = ssc_pkg::WW'(1);
      tn5_d = ssc_pkg::WW'(f4_q);
      td5_d = ssc_pkg::WW'(e4_q);
    end else if (sn_big) begin
      // s clamps to one, t = (b + f) / e
      sn5_d = ssc_pkg::WW'(1);
      sd5_d = ssc_pkg::WW'(1);
      tn5_d = ssc_pkg::WW'(b4_q) + ssc_pkg::WW'(f4_q);
      td5_d = ssc_pkg::WW'(e4_q);
    end else begin
      sn5_d = sn4_q;
      sd5_d = den4_q;
      tn5_d = tn4_q;
      td5_d = den4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sn5_q  <= sn5_d;
    sd5_q  <= sd5_d;
    tn5_q  <= tn5_d;
    td5_q  <= td5_d;
    a5_q   <= a4_q;
    b5_q   <= b4_q;
    c5_q   <= c4_q;
    par5_q <= (den4_q == '0) || (den4_q < lim_w);
  end

  // stage 6: when t leaves [0,1], s is recomputed against a
  logic                          tn_neg, tn_big;
  logic signed [ssc_pkg::WW-1:0] sn6_d, sd6_d;
  logic signed [ssc_pkg::WW-1:0] sn6_q, sd6_q, tn6_q, td6_q;
  logic                          par6_q;

  assign tn_neg = tn5_q[ssc_pkg::WW-1];
  assign tn_big = td5_q < tn5_q;

  always_comb begin
    priority if (tn_neg) begin
      sn6_d = -ssc_pkg::WW'(c5_q);
      sd6_d = ssc_pkg::WW'(a5_q);
    end else if (tn_big) begin
      sn6_d = ssc_pkg::WW'(b5_q) - ssc_pkg::WW'(c5_q);
      sd6_d = ssc_pkg::WW'(a5_q);
    end else begin
      sn6_d = sn5_q;
      sd6_d = sd5_q;
    end
  end

  // the t ratio clamps itself: negative gives zero, above one gives one
  always_ff @(posedge clk_i) begin
    sn6_q  <= sn6_d;
    sd6_q  <= sd6_d;
    tn6_q  <= tn5_q;
    td6_q  <= td5_q;
    par6_q <= par5_q;
  end

  // quotient pipelines
  logic [ssc_pkg::OUT_W-1:0] s_div, t_div;

  ssc_div u_div_s (.clk_i(clk_i), .num_i(sn6_q), .den_i(sd6_q), .q_o(s_div));
  ssc_div u_div_t (.clk_i(clk_i), .num_i(tn6_q), .den_i(td6_q), .q_o(t_div));

  logic [DL-1:0] par_d_q;

  always_ff @(posedge clk_i) begin
    par_d_q <= {par_d_q[DL-2:0], par6_q};
  end

  // output register, parallel edges force zeros
  logic [ssc_pkg::OUT_W-1:0] s_out_q, t_out_q;
  logic                      err_out_q;

  always_ff @(posedge clk_i) begin
    err_out_q <= par_d_q[DL-1];
    s_out_q   <= par_d_q[DL-1] ? '0 : s_div;
    t_out_q   <= par_d_q[DL-1] ? '0 : t_div;
  end

  assign done_o           = done_q;
  assign param_first_o    = s_out_q;
  assign param_second_o   = t_out_q;
  assign parallel_error_o = err_out_q;

  // every accepted item gives its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(ssc_pkg::TOTAL_LAT) done_o)
    else $error("result strobe missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, ssc_pkg::TOTAL_LAT))
    else $error("result strobe without an item");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && parallel_error_o |-> param_first_o == '0 && param_second_o == '0)
    else $error("parallel result carries nonzero parameters");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> param_first_o <= ssc_pkg::PARAM_ONE && param_second_o <= ssc_pkg::PARAM_ONE)
    else $error("parameter above one");

endmodule
